@@ src/assert_macros.svh @@
// Assertion helpers; clocked on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("label failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("label failed");

`endif

@@ src/ple_pkg.sv @@
`timescale 1ns / 1ps
package ple_pkg;

    localparam int DEPTH      = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int GRP        = 8;
    localparam int NGRP       = DEPTH / GRP;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUB_W      = $clog2(GRP);
    localparam int GIDX_W     = $clog2(NGRP);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_LOCATE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic             en;
        t_cell_op         op;
        logic [IDX_W-1:0] pos0;
        logic [CNT_W-1:0] count;
        t_elem            value;
    } t_cell_ctrl;

    typedef struct packed {
        logic             hit;
        logic [SUB_W-1:0] sub;
        t_elem            pick;
    } t_grp_res;

endpackage

@@ src/positional_list_engine_core.sv @@
`timescale 1ns / 1ps
// Results pass the entry cells, then the group registers that gather read and match flags,
// then the output register. A new item is accepted only after the previous result is loaded,
// which waits while the output still holds an untaken result; all entry cells update together.
// Only one command is in flight; the output register may still hold the previous result.
// Reset (synchronous, active low) empties the list; entry contents are undefined until written.
module positional_list_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[6:0], value[38:7], zero[39]
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // ok[0], read_value[32:1], found_position[39:33],
                                       // list_length[46:40], is_empty[47]
);
    import ple_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CELL = 3'b010,
        S_GRP  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_cmd             r_cmd;
    logic             r_ok;
    logic             r_out_valid;
    logic             r_out_ok;
    logic [VAL_W-1:0] r_out_read;
    logic [POS_W-1:0] r_out_found;
    logic [CNT_W-1:0] r_out_len;
    logic             r_out_empty;

    logic             accept;
    t_cmd             in_cmd;
    logic [POS_W-1:0] in_pos;
    t_elem            in_val;
    logic [CNT_W:0]   pos_ext;
    logic [CNT_W:0]   cnt_ext;
    logic             ins_ok, rd_ok, cmd_ok;
    t_cell_ctrl       ctrl;

    t_elem            cell_data  [DEPTH];
    t_elem            cell_pick  [DEPTH];
    logic [DEPTH-1:0] cell_match;
    t_grp_res         grp_res    [NGRP];

    logic              hit_any;
    logic [GIDX_W-1:0] gsel;
    logic [SUB_W-1:0]  ssel;
    t_elem             pick_or;
    logic              out_load;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_cmd = t_cmd'(s_axis_tuser[CMD_W-1:0]);
    assign in_pos = s_axis_tdata[POS_W-1:0];
    assign in_val = t_elem'(s_axis_tdata[POS_W +: VAL_W]);

    assign pos_ext = (CNT_W + 1)'(in_pos);
    assign cnt_ext = {1'b0, r_count};
    assign ins_ok  = (in_pos != '0) && (pos_ext <= cnt_ext + (CNT_W + 1)'(1))
                     && (r_count < CNT_W'(DEPTH));
    assign rd_ok   = (in_pos != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        cmd_ok     = 1'b0;
        n_count    = r_count;
        ctrl.en    = accept;
        ctrl.op    = CELL_HOLD;
        ctrl.pos0  = IDX_W'(in_pos - POS_W'(1));
        ctrl.count = r_count;
        ctrl.value = in_val;
        case (in_cmd)
            CMD_CLEAR: begin
                cmd_ok  = 1'b1;
                n_count = '0;
            end
            CMD_INSERT: begin
                cmd_ok = ins_ok;
                if (ins_ok) begin
                    ctrl.op = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                cmd_ok = rd_ok;
                if (rd_ok) begin
                    ctrl.op = CELL_DELETE;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_GET: begin
                cmd_ok = rd_ok;
            end
            default: begin
            end
        endcase
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_elem left_d, right_d;
        if (k == 0) begin : g_first
            assign left_d = cell_data[k];
        end else begin : g_mid
            assign left_d = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right_d = cell_data[k];
        end else begin : g_body
            assign right_d = cell_data[k+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_index (IDX_W'(k)),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[k]),
            .o_pick  (cell_pick[k]),
            .o_match (cell_match[k])
        );
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        t_elem grp_pick [GRP];
        for (genvar k = 0; k < GRP; k++) begin : g_tap
            assign grp_pick[k] = cell_pick[g*GRP + k];
        end
        ple_grp u_grp (
            .i_clk   (i_clk),
            .i_pick  (grp_pick),
            .i_match (cell_match[g*GRP +: GRP]),
            .o_res   (grp_res[g])
        );
    end

    always_comb begin
        hit_any = 1'b0;
        gsel    = '0;
        ssel    = '0;
        pick_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            pick_or = pick_or | grp_res[g].pick;
            if (!hit_any && grp_res[g].hit) begin
                hit_any = 1'b1;
                gsel    = GIDX_W'(g);
                ssel    = grp_res[g].sub;
            end
        end
    end

    assign out_load = (r_state == S_GRP) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CELL;
            S_CELL:  n_state = S_GRP;
            S_GRP:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= in_cmd;
            r_ok  <= cmd_ok;
        end
        if (out_load) begin
            r_out_len   <= r_count;
            r_out_empty <= (r_count == '0);
            if (r_cmd == CMD_LOCATE) begin
                r_out_ok    <= hit_any;
                r_out_found <= hit_any ? POS_W'(CNT_W'({gsel, ssel}) + CNT_W'(1)) : '0;
            end else begin
                r_out_ok    <= r_ok;
                r_out_found <= '0;
            end
            if (r_ok && (r_cmd == CMD_GET || r_cmd == CMD_DELETE)) begin
                r_out_read <= VAL_W'(pick_or);
            end else begin
                r_out_read <= '0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_empty, r_out_len, r_out_found, r_out_read, r_out_ok};

    `ASSERT_NEVER(a_count_max, r_count > CNT_W'(DEPTH), "list length above depth")
    `ASSERT_NEXT(a_accept_cell, accept, r_state == S_CELL)
    `ASSERT_NEXT(a_count_hold, !accept, $stable(r_count))
    `ASSERT_SAME(a_empty_len, r_out_valid, r_out_empty == (r_out_len == '0))

endmodule

@@ src/ple_cell.sv @@
`timescale 1ns / 1ps
module ple_cell (
    input  logic                     i_clk,
    input  ple_pkg::t_cell_ctrl      i_ctrl,
    input  logic [ple_pkg::IDX_W-1:0] i_index,
    input  ple_pkg::t_elem           i_left,
    input  ple_pkg::t_elem           i_right,
    output ple_pkg::t_elem           o_data,
    output ple_pkg::t_elem           o_pick,
    output logic                     o_match
);
    import ple_pkg::*;

    t_elem r_data;
    t_elem r_pick;
    logic  r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_pick  <= (i_index == i_ctrl.pos0) ? r_data : '0;
            r_match <= (r_data == i_ctrl.value) && (CNT_W'(i_index) < i_ctrl.count);
            case (i_ctrl.op)
                CELL_INSERT: begin
                    if (i_index == i_ctrl.pos0) begin
                        r_data <= i_ctrl.value;
                    end else if (i_index > i_ctrl.pos0) begin
                        r_data <= i_left;
                    end
                end
                CELL_DELETE: begin
                    if (i_index >= i_ctrl.pos0) begin
                        r_data <= i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_data  = r_data;
    assign o_pick  = r_pick;
    assign o_match = r_match;

endmodule

@@ src/ple_grp.sv @@
`timescale 1ns / 1ps
module ple_grp (
    input  logic                  i_clk,
    input  ple_pkg::t_elem        i_pick [ple_pkg::GRP],
    input  logic [ple_pkg::GRP-1:0] i_match,
    output ple_pkg::t_grp_res     o_res
);
    import ple_pkg::*;

    t_grp_res r_res;
    t_grp_res n_res;

    always_comb begin
        n_res = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            n_res.pick = n_res.pick | i_pick[k];
            if (i_match[k]) begin
                n_res.hit = 1'b1;
                n_res.sub = SUB_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
